>>> rtl/gbmd_pkg.sv
// ----------------------------------------------------------------------------
// gbmd_pkg
// Shared constants, types and helper functions of the gray box blur motion
// detect unit.
// ----------------------------------------------------------------------------
package gbmd_pkg;

   // geometry and kernel
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int KSIZE      = 3;
   localparam int KLO        = KSIZE / 2;
   localparam int KHI        = KSIZE - 1 - KLO;
   localparam int KDIM       = KSIZE * KSIZE;

   // widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int DIM_W  = 11;
   localparam int CNT_W  = 21;
   localparam int BG_AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int POS_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 3;
   localparam int SLOT_W = (KSIZE > 1) ? $clog2(KSIZE) : 1;
   localparam int SW1    = SLOT_W + 1;
   localparam int SUM_W  = $clog2(KDIM * 255 + 1);
   localparam int PIX_W  = 8;

   // division by KDIM as multiply by rounded-up reciprocal
   localparam int DIV_SH = 24;
   localparam int RCP_W  = DIV_SH + 1;
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(((1 << DIV_SH) + KDIM - 1) / KDIM);
   localparam int PROD_W = SUM_W + RCP_W;

   // configuration port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 21;
   localparam logic [CSR_AW-1:0] CSR_FRAME_WIDTH     = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_COUNT_THRESHOLD = 2'd2;

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // luma weights in Q0.16
   localparam logic [24:0] GRAY_R    = 25'd19588;
   localparam logic [24:0] GRAY_G    = 25'd38470;
   localparam logic [24:0] GRAY_B    = 25'd7471;
   localparam logic [24:0] GRAY_HALF = 25'd32768;

   // controller to datapath commands
   typedef struct packed {
      logic clr;
      logic take;
      logic load;
      logic pixel;
      logic row_setup;
      logic rd;
      logic acc;
      logic dv;
      logic cmp;
      logic res;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_done;
      logic row_end;
      logic row_go;
      logic frame_done;
      logic last_tap;
      logic col_last;
      logic rsp_free;
   } ctrl_sts_type;

   // rgb to gray, rounded half up
   function automatic logic [PIX_W-1:0] to_gray(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
      logic [24:0] acc;
      acc = GRAY_R * 25'(r) + GRAY_G * 25'(g) + GRAY_B * 25'(b) + GRAY_HALF;
      return acc[23:16];
   endfunction

   // modulo KSIZE of a value below twice KSIZE
   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SW1-1:0] v);
      logic [SW1-1:0] r;
      r = (v >= SW1'(KSIZE)) ? (v - SW1'(KSIZE)) : v;
      return r[SLOT_W-1:0];
   endfunction

endpackage

>>> rtl/gbmd_ctrl.sv
// ----------------------------------------------------------------------------
// gbmd_ctrl
// Sequencer: line buffer clear, item intake, row blur sweep and result.
// ----------------------------------------------------------------------------
module gbmd_ctrl
   import gbmd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_operation,
   output logic         req_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_LOAD = 4'd2;
   localparam logic [3:0] ST_GRAY = 4'd3;
   localparam logic [3:0] ST_ROW  = 4'd4;
   localparam logic [3:0] ST_RD   = 4'd5;
   localparam logic [3:0] ST_ACC  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_CMP  = 4'd8;
   localparam logic [3:0] ST_RES  = 4'd9;

   logic [3:0] state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR:  if (sts.clr_done) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) state_in = (req_operation == OP_PIXEL) ? ST_GRAY : ST_LOAD;
         ST_LOAD: state_in = ST_IDLE;
         ST_GRAY: state_in = sts.row_end ? ST_ROW : ST_IDLE;
         ST_ROW: begin
            if (sts.row_go) state_in = ST_RD;
            else state_in = sts.frame_done ? ST_RES : ST_IDLE;
         end
         ST_RD:   state_in = ST_ACC;
         ST_ACC:  state_in = sts.last_tap ? ST_DIV : ST_RD;
         ST_DIV:  state_in = ST_CMP;
         ST_CMP:  state_in = sts.col_last ? ST_ROW : ST_RD;
         ST_RES:  if (sts.rsp_free) state_in = ST_IDLE;
         default: state_in = ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLR;
      else state_ff <= state_in;
   end

   // command decode
   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.clr       = (state_ff == ST_CLR);
   assign cmd.take      = (state_ff == ST_IDLE) && req_valid;
   assign cmd.load      = (state_ff == ST_LOAD);
   assign cmd.pixel     = (state_ff == ST_GRAY);
   assign cmd.row_setup = (state_ff == ST_ROW);
   assign cmd.rd        = (state_ff == ST_RD);
   assign cmd.acc       = (state_ff == ST_ACC);
   assign cmd.dv        = (state_ff == ST_DIV);
   assign cmd.cmp       = (state_ff == ST_CMP);
   assign cmd.res       = (state_ff == ST_RES) && sts.rsp_free;

   // result waits in its state while the output word is still held
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RES && !sts.rsp_free) |=> (state_ff == ST_RES))
      else $error("result state left while output busy");

   // a row sweep never starts before the clear is finished
   a_clr_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR && !sts.clr_done) |=> (state_ff == ST_CLR))
      else $error("clear pass cut short");

   // tap loop alternates read and accumulate
   a_tap_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |=> (state_ff == ST_ACC))
      else $error("tap read not followed by accumulate");

endmodule

>>> rtl/gbmd_dpath.sv
// ----------------------------------------------------------------------------
// gbmd_dpath
// Datapath: configuration, background memory, line buffers, blur
// accumulator, reciprocal divide, tally and result register.
// ----------------------------------------------------------------------------
module gbmd_dpath
   import gbmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output ctrl_sts_type      sts,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_background_level,
   input  logic              csr_write_enable,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_write_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_motion_detected,
   output logic [CNT_W-1:0]  rsp_differing_count
);

   // configuration
   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CNT_W-1:0] thresh_ff, thresh_in;

   // captured word
   logic [7:0] red_ff, green_ff, blue_ff, bglev_ff;

   // raster and load position
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] row_slot_ff, row_slot_in;
   logic [BG_AW-1:0]  load_pos_ff, load_pos_in;
   logic [CNT_W-1:0]  tally_ff, tally_in;

   // row sweep
   logic [ROW_W-1:0]        newest_ff, newest_in;
   logic signed [POS_W-1:0] o_ff, o_in, last_ff, last_in, x_ff, x_in;
   logic [SLOT_W-1:0]       o_slot_ff, o_slot_in;
   logic                    fdone_ff, fdone_in;
   logic [COL_W-1:0]        c_ff, c_in;
   logic [SLOT_W-1:0]       e_ff, e_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic                    xok_ff, xok_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [BG_AW-1:0]        o_w_ff;
   logic [COL_W-1:0]        clr_addr_ff, clr_addr_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in, rsp_md_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;

   // memories
   logic [PIX_W-1:0] bg_mem [MAX_WIDTH*MAX_HEIGHT];
   logic [PIX_W-1:0] bg_rd_ff;
   logic [PIX_W-1:0] lb_rd_ff [KSIZE];

   // combinational helpers
   logic [DIM_W-1:0]        w_eff, h_eff;
   logic                    row_end, frame_end;
   logic signed [POS_W-1:0] row_k;
   logic [PIX_W-1:0]        gray;
   logic [SUM_W-1:0]        rowsum;
   logic [2*DIM_W-1:0]      frame_px;
   logic [BG_AW:0]          pos_next;
   logic [PIX_W-1:0]        blurred;
   logic                    differ;
   logic [COL_W-1:0]        lb_addr;

   // effective geometry
   always_comb begin
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
      else h_eff = height_ff;
   end

   assign row_end   = (DIM_W'(col_ff) + DIM_W'(1)) >= w_eff;
   assign frame_end = (DIM_W'(row_ff) + DIM_W'(1)) >= h_eff;
   assign row_k     = $signed(POS_W'(row_ff)) - $signed(POS_W'(KHI));
   assign gray      = to_gray(red_ff, green_ff, blue_ff);
   assign frame_px  = w_eff * h_eff;
   assign pos_next  = (BG_AW+1)'(load_pos_ff) + (BG_AW+1)'(1);
   assign blurred   = prod_ff[DIV_SH +: PIX_W];
   assign differ    = (blurred != bg_rd_ff);
   assign lb_addr   = x_ff[COL_W-1:0];

   // sum of the window rows at the current column
   always_comb begin
      logic [SLOT_W-1:0]       base;
      logic [SLOT_W-1:0]       sd;
      logic signed [POS_W-1:0] y;
      base   = wrap_slot(SW1'(o_slot_ff) + SW1'(KSIZE - KLO));
      rowsum = '0;
      for (int d = 0; d < KSIZE; d++) begin
         y  = o_ff - $signed(POS_W'(KLO)) + $signed(POS_W'(d));
         sd = wrap_slot(SW1'(base) + SW1'(d));
         if (y >= 0 && y < $signed(POS_W'(h_eff)) && y <= $signed(POS_W'(newest_ff)))
            rowsum = rowsum + SUM_W'(lb_rd_ff[sd]);
      end
   end

   // next state of the datapath registers
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      thresh_in    = thresh_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_slot_in  = row_slot_ff;
      load_pos_in  = load_pos_ff;
      tally_in     = tally_ff;
      newest_in    = newest_ff;
      o_in         = o_ff;
      last_in      = last_ff;
      o_slot_in    = o_slot_ff;
      fdone_in     = fdone_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      e_in         = e_ff;
      acc_in       = acc_ff;
      xok_in       = xok_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff;

      // configuration writes
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:     width_in  = csr_write_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:    height_in = csr_write_data[DIM_W-1:0];
            CSR_COUNT_THRESHOLD: thresh_in = csr_write_data[CNT_W-1:0];
            default: ;
         endcase
      end

      // line buffer clear sweep
      if (cmd.clr) clr_addr_in = clr_addr_ff + COL_W'(1);

      // background load address wraps at the frame size
      if (cmd.load) begin
         if (pos_next >= (BG_AW+1)'(frame_px)) load_pos_in = '0;
         else load_pos_in = pos_next[BG_AW-1:0];
      end

      // raster advance and row emit setup
      if (cmd.pixel) begin
         if (!row_end) begin
            col_in = col_ff + COL_W'(1);
         end else begin
            col_in    = '0;
            newest_in = row_ff;
            if (!frame_end) begin
               o_in        = row_k;
               last_in     = row_k;
               o_slot_in   = wrap_slot(SW1'(row_slot_ff) + SW1'(KSIZE - KHI));
               fdone_in    = 1'b0;
               row_in      = row_ff + ROW_W'(1);
               row_slot_in = wrap_slot(SW1'(row_slot_ff) + SW1'(1));
            end else begin
               if (row_k < 0) begin
                  o_in      = '0;
                  o_slot_in = '0;
               end else begin
                  o_in      = row_k;
                  o_slot_in = wrap_slot(SW1'(row_slot_ff) + SW1'(KSIZE - KHI));
               end
               if (DIM_W'(row_ff) > h_eff - DIM_W'(1))
                  last_in = $signed(POS_W'(h_eff - DIM_W'(1)));
               else
                  last_in = $signed(POS_W'(row_ff));
               fdone_in    = 1'b1;
               row_in      = '0;
               row_slot_in = '0;
            end
         end
      end

      // start of an output row
      if (cmd.row_setup) begin
         c_in   = '0;
         x_in   = -$signed(POS_W'(KLO));
         e_in   = '0;
         acc_in = '0;
      end

      // tap read: note whether the column lies inside the frame
      if (cmd.rd) xok_in = (x_ff >= 0) && (x_ff < $signed(POS_W'(w_eff)));

      // tap accumulate
      if (cmd.acc) begin
         if (xok_ff) acc_in = acc_ff + rowsum;
         e_in = e_ff + SLOT_W'(1);
         x_in = x_ff + $signed(POS_W'(1));
      end

      // compare and tally, then next column or next row
      if (cmd.cmp) begin
         if (differ && tally_ff != '1) tally_in = tally_ff + CNT_W'(1);
         if ((DIM_W'(c_ff) + DIM_W'(1)) < w_eff) begin
            c_in   = c_ff + COL_W'(1);
            x_in   = $signed(POS_W'(c_ff)) + $signed(POS_W'(1)) - $signed(POS_W'(KLO));
            e_in   = '0;
            acc_in = '0;
         end else begin
            o_in      = o_ff + $signed(POS_W'(1));
            o_slot_in = wrap_slot(SW1'(o_slot_ff) + SW1'(1));
         end
      end

      // result word
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.res) begin
         rsp_valid_in = 1'b1;
         tally_in     = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_W'(640);
         height_ff    <= DIM_W'(480);
         thresh_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         row_slot_ff  <= '0;
         load_pos_ff  <= '0;
         tally_ff     <= '0;
         fdone_ff     <= 1'b0;
         e_ff         <= '0;
         o_slot_ff    <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thresh_ff    <= thresh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_slot_ff  <= row_slot_in;
         load_pos_ff  <= load_pos_in;
         tally_ff     <= tally_in;
         fdone_ff     <= fdone_in;
         e_ff         <= e_in;
         o_slot_ff    <= o_slot_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      newest_ff <= newest_in;
      o_ff      <= o_in;
      last_ff   <= last_in;
      c_ff      <= c_in;
      x_ff      <= x_in;
      acc_ff    <= acc_in;
      xok_ff    <= xok_in;
      if (cmd.take) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         bglev_ff <= req_background_level;
      end
      if (cmd.row_setup)
         o_w_ff <= BG_AW'(o_ff[ROW_W-1:0]) * BG_AW'(w_eff);
      if (cmd.dv) prod_ff <= acc_ff * RECIP;
      if (cmd.res) begin
         rsp_md_ff  <= (tally_ff > thresh_ff);
         rsp_cnt_ff <= tally_ff;
      end
   end

   // background frame memory
   always_ff @(posedge clock) begin
      if (cmd.load) bg_mem[load_pos_ff] <= bglev_ff;
      if (cmd.dv) bg_rd_ff <= bg_mem[o_w_ff + BG_AW'(c_ff)];
   end

   // one line memory per kernel row
   for (genvar j = 0; j < KSIZE; j++) begin : g_line
      logic [PIX_W-1:0] lb_mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (cmd.clr)
            lb_mem[clr_addr_ff] <= '0;
         else if (cmd.pixel && row_slot_ff == SLOT_W'(j))
            lb_mem[col_ff] <= gray;
         lb_rd_ff[j] <= lb_mem[lb_addr];
      end
   end

   // status
   assign sts.clr_done   = (clr_addr_ff == COL_W'(MAX_WIDTH - 1));
   assign sts.row_end    = row_end;
   assign sts.row_go     = (o_ff >= 0) && (o_ff <= last_ff);
   assign sts.frame_done = fdone_ff;
   assign sts.last_tap   = (e_ff == SLOT_W'(KSIZE - 1));
   assign sts.col_last   = (DIM_W'(c_ff) + DIM_W'(1)) >= w_eff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motion_detected = rsp_md_ff;
   assign rsp_differing_count = rsp_cnt_ff;

   // tally only grows inside a frame
   a_tally_mono: assert property (@(posedge clock) disable iff (reset)
      !cmd.res |=> (tally_ff >= $past(tally_ff)))
      else $error("tally decreased without a result");

   // ring slots stay below the kernel size
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (row_slot_ff < SLOT_W'(KSIZE)) && (o_slot_ff < SLOT_W'(KSIZE)))
      else $error("ring slot out of range");

   // a taken result clears the tally
   a_res_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.res |=> (tally_ff == '0) && rsp_valid_ff)
      else $error("result not loaded or tally not cleared");

endmodule

>>> rtl/gray_box_blur_motion_detect_unit.sv
// ----------------------------------------------------------------------------
// gray_box_blur_motion_detect_unit
// Gray conversion, box blur and background compare with a motion verdict.
// ----------------------------------------------------------------------------
// a load or mid-row pixel runs the intake then the load or gray state; each
//   blur row emitted at a row end runs a row setup, then per column a read
//   and accumulate per tap on the shared tap accumulator that reads all line
//   memories once per tap, a divide and a compare; at the frame end up to
//   KHI+1 rows are emitted, then the result word; no word is taken meanwhile
// reset: synchronous; a line buffer clear follows, during which no word is
//   taken; configuration writes are taken as ever
module gray_box_blur_motion_detect_unit
   import gbmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_background_level,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_motion_detected,
   output logic [CNT_W-1:0]  rsp_differing_count,
   input  logic              csr_write_enable,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_write_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // sequencer
   gbmd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // datapath
   gbmd_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .req_background_level (req_background_level),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_motion_detected  (rsp_motion_detected),
      .rsp_differing_count  (rsp_differing_count)
   );

endmodule
